// File: rtl/vec3_normalize_top_assert.svh
// Assertion macros for the vec3_normalize RTL, used by vn_skid.
`ifndef VEC3_NORMALIZE_TOP_ASSERT_SVH
`define VEC3_NORMALIZE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VN_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/vn_pkg.sv
// Shared types and constants of the vec3_normalize block.
`default_nettype none
package vn_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 24;
   localparam int SQ_W          = 48;
   localparam int ROOT_W        = 49;
   localparam int SQRT_STEPS    = 25;
   localparam logic [SQ_W-1:0] THR_RESET = 48'd4295;

   typedef struct packed {
      logic                     valid;
      logic                     tiny;
      logic                     zero;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } meta_type;

   typedef struct packed {
      logic                     is_tiny;
      logic        [DATA_W-1:0] length;
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] x;
   } rsp_type;
endpackage
`default_nettype wire

// File: rtl/vn_sq.sv
// Squared length and threshold compare, two register stages.
`default_nettype none
module vn_sq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [23:0]        in_x,
   input  logic signed [23:0]        in_y,
   input  logic signed [23:0]        in_z,
   input  logic [47:0]               thr,
   output vn_pkg::meta_type          meta_out,
   output logic [47:0]               s_out,
   output logic [47:0]               sq_out [3]
);
   import vn_pkg::*;

   logic [DATA_W-1:0] mag [3];
   logic [SQ_W-1:0]   sq_ff [3];
   logic [SQ_W-1:0]   sq_in [3];
   meta_type          meta_a_ff;
   meta_type          meta_a_in;
   meta_type          meta_b_ff;
   meta_type          meta_b_in;
   logic [SQ_W-1:0]   s_ff;
   logic [SQ_W-1:0]   s_in;

   always_comb begin
      mag[0] = in_x[DATA_W-1] ? DATA_W'(-in_x) : DATA_W'(in_x);
      mag[1] = in_y[DATA_W-1] ? DATA_W'(-in_y) : DATA_W'(in_y);
      mag[2] = in_z[DATA_W-1] ? DATA_W'(-in_z) : DATA_W'(in_z);
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(mag[i]) * SQ_W'(mag[i]);
      end
      meta_a_in       = '0;
      meta_a_in.valid = in_valid;
      meta_a_in.x     = in_x;
      meta_a_in.y     = in_y;
      meta_a_in.z     = in_z;
      // sum of three squares stays below 2^48
      s_in            = sq_ff[0] + sq_ff[1] + sq_ff[2];
      meta_b_in       = meta_a_ff;
      meta_b_in.tiny  = s_in < thr;
      meta_b_in.zero  = s_in == '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_a_ff.tiny <= meta_a_in.tiny;
         meta_a_ff.zero <= meta_a_in.zero;
         meta_a_ff.x    <= meta_a_in.x;
         meta_a_ff.y    <= meta_a_in.y;
         meta_a_ff.z    <= meta_a_in.z;
         meta_b_ff.tiny <= meta_b_in.tiny;
         meta_b_ff.zero <= meta_b_in.zero;
         meta_b_ff.x    <= meta_b_in.x;
         meta_b_ff.y    <= meta_b_in.y;
         meta_b_ff.z    <= meta_b_in.z;
         s_ff           <= s_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq_in[i];
         end
      end
      if (reset) begin
         meta_a_ff.valid <= 1'b0;
         meta_b_ff.valid <= 1'b0;
      end else if (en) begin
         meta_a_ff.valid <= meta_a_in.valid;
         meta_b_ff.valid <= meta_b_in.valid;
      end
   end

   assign meta_out  = meta_b_ff;
   assign s_out     = s_ff;
   // the squares are still needed by the unit lanes, so a further register lines them up with the sum
   logic [SQ_W-1:0] sqd_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sqd_ff[i] <= sq_ff[i];
         end
      end
   end
   assign sq_out[0] = sqd_ff[0];
   assign sq_out[1] = sqd_ff[1];
   assign sq_out[2] = sqd_ff[2];
endmodule
`default_nettype wire

// File: rtl/vn_step.sv
// One pipeline stage: one square-root step and, in the active stages, one quotient bit per lane.
`default_nettype none
module vn_step #(
   parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF,
   parameter int STAGE     = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  vn_pkg::meta_type            meta_in,
   input  logic [47:0]                 s_in,
   input  logic [48:0]                 rem_in,
   input  logic [48:0]                 root_in,
   input  logic [2*FRAC_BITS+51:0]     rr_in [3],
   input  logic [FRAC_BITS+49:0]       dd_in [3],
   input  logic [FRAC_BITS+1:0]        uu_in [3],
   output vn_pkg::meta_type            meta_out,
   output logic [47:0]                 s_out,
   output logic [48:0]                 rem_out,
   output logic [48:0]                 root_out,
   output logic [2*FRAC_BITS+51:0]     rr_out [3],
   output logic [FRAC_BITS+49:0]       dd_out [3],
   output logic [FRAC_BITS+1:0]        uu_out [3]
);
   import vn_pkg::*;

   localparam int W      = 2*FRAC_BITS + 52;
   localparam int DW     = FRAC_BITS + 50;
   localparam int UW     = FRAC_BITS + 2;
   localparam int SBIT   = 2*(SQRT_STEPS - 1 - STAGE);
   localparam logic [ROOT_W-1:0] BITV = ROOT_W'(1) << SBIT;
   localparam bit ACTIVE = STAGE <= FRAC_BITS + 1;
   localparam int B      = ACTIVE ? FRAC_BITS + 1 - STAGE : 0;

   meta_type          meta_ff;
   logic [SQ_W-1:0]   s_ff;
   logic [ROOT_W-1:0] rem_ff, rem_in_n;
   logic [ROOT_W-1:0] root_ff, root_in_n;
   logic [ROOT_W-1:0] trial;
   logic [W-1:0]      sb;
   logic [W-1:0]      t [3];
   logic [W-1:0]      rr_ff [3], rr_in_n [3];
   logic [DW-1:0]     dd_ff [3], dd_in_n [3];
   logic [UW-1:0]     uu_ff [3], uu_in_n [3];

   always_comb begin
      trial = root_in + BITV;
      if (rem_in >= trial) begin
         rem_in_n  = rem_in - trial;
         root_in_n = (root_in >> 1) + BITV;
      end else begin
         rem_in_n  = rem_in;
         root_in_n = root_in >> 1;
      end
      sb = W'(s_in) << B;
      for (int i = 0; i < 3; i++) begin
         // test the growth from u^2 to (u + 2^b)^2, times s, against the remaining numerator
         t[i] = ((W'(dd_in[i]) << 1) + sb) << B;
         if (ACTIVE && rr_in[i] >= t[i]) begin
            rr_in_n[i] = rr_in[i] - t[i];
            dd_in_n[i] = dd_in[i] + DW'(sb);
            uu_in_n[i] = uu_in[i] | (UW'(1) << B);
         end else begin
            rr_in_n[i] = rr_in[i];
            dd_in_n[i] = dd_in[i];
            uu_in_n[i] = uu_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff.tiny <= meta_in.tiny;
         meta_ff.zero <= meta_in.zero;
         meta_ff.x    <= meta_in.x;
         meta_ff.y    <= meta_in.y;
         meta_ff.z    <= meta_in.z;
         s_ff         <= s_in;
         rem_ff       <= rem_in_n;
         root_ff      <= root_in_n;
         for (int i = 0; i < 3; i++) begin
            rr_ff[i] <= rr_in_n[i];
            dd_ff[i] <= dd_in_n[i];
            uu_ff[i] <= uu_in_n[i];
         end
      end
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else if (en) begin
         meta_ff.valid <= meta_in.valid;
      end
   end

   assign meta_out = meta_ff;
   assign s_out    = s_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign rr_out   = rr_ff;
   assign dd_out   = dd_ff;
   assign uu_out   = uu_ff;
endmodule
`default_nettype wire

// File: rtl/vn_skid.sv
// Output register with one skid entry.
`default_nettype none
`include "vec3_normalize_top_assert.svh"
module vn_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  vn_pkg::rsp_type  in_data,
   input  logic             rsp_tready,
   output logic             out_valid,
   output vn_pkg::rsp_type  out_data,
   output logic             full
);
   import vn_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    full_ff, full_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   always_comb begin
      take         = out_valid_ff && rsp_tready;
      out_valid_in = out_valid_ff;
      full_in      = full_ff;
      out_in       = out_ff;
      skid_in      = skid_ff;
      if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in = in_data;
            full_in = 1'b1;
         end
      end else if (take) begin
         if (full_ff) begin
            out_in  = skid_ff;
            full_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         full_ff      <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign full      = full_ff;

   `VN_ASSERT_IMPLY(a_skid_behind_out, full_ff, out_valid_ff, "skid full with empty output")
   `VN_ASSERT_IMPLY(a_no_entry_when_full, full_ff, !in_valid, "request entered a full skid")
   `VN_ASSERT_NEXT(a_skid_held, full_ff && !rsp_tready, full_ff && out_valid_ff, "skid lost")
   `VN_ASSERT_IMPLY(a_tiny_zero_len, out_valid_ff && out_ff.is_tiny, out_ff.length == '0,
      "tiny result with nonzero length")
endmodule
`default_nettype wire

// File: rtl/vec3_normalize_top.sv
// Top level of the vec3_normalize block.
`default_nettype none
// Normalises one signed Q7.16 3D vector per request. The squared length is
// formed exactly and compared with the csr threshold; below it the request
// is echoed with length 0 and is_tiny set. Otherwise length = floor(sqrt(S))
// and each component is rounded to nearest (ties away from zero) of v/|v|.
// One request is accepted every clock while the output side keeps up.
// From acceptance to rsp_tvalid: the squares are registered at the accepting
// edge, then their sum, then 25 stages each retire one root bit pair (the
// first FRAC_BITS+2 also one quotient bit per component), then the output
// register. A single skid entry behind it takes a result while the consumer
// stalls and freezes the pipeline while it is occupied.
// The threshold is to be written only while the block is idle.
module vec3_normalize_top #(
   parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // in_x [23:0], in_y [47:24], in_z [71:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // out_x, out_y, out_z, length (24 bits each)
   output logic [0:0]  rsp_tuser,   // is_tiny
   input  logic        csr_wen,
   input  logic [47:0] csr_wdata    // tiny_threshold, unsigned Q16.32
);
   import vn_pkg::*;

   localparam int W  = 2*FRAC_BITS + 52;
   localparam int DW = FRAC_BITS + 50;
   localparam int UW = FRAC_BITS + 2;

   logic [SQ_W-1:0] thr_ff;
   logic            en;
   logic            full;

   meta_type          meta_c [SQRT_STEPS+1];
   logic [SQ_W-1:0]   s_c    [SQRT_STEPS+1];
   logic [ROOT_W-1:0] rem_c  [SQRT_STEPS+1];
   logic [ROOT_W-1:0] root_c [SQRT_STEPS+1];
   logic [W-1:0]      rr_c   [SQRT_STEPS+1][3];
   logic [DW-1:0]     dd_c   [SQRT_STEPS+1][3];
   logic [UW-1:0]     uu_c   [SQRT_STEPS+1][3];
   logic [SQ_W-1:0]   sq     [3];

   meta_type          last;
   logic [UW:0]       q [3];
   logic [DATA_W-1:0] comp [3];
   rsp_type           res;
   rsp_type           out;
   logic              out_valid;

   // hold the threshold; it is to be written only while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   // advance the whole pipe unless the skid entry is occupied
   assign en         = !full;
   assign req_tready = en;

   vn_sq u_sq (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_x     (req_tdata[23:0]),
      .in_y     (req_tdata[47:24]),
      .in_z     (req_tdata[71:48]),
      .thr      (thr_ff),
      .meta_out (meta_c[0]),
      .s_out    (s_c[0]),
      .sq_out   (sq)
   );

   // seed the recurrences: root remainder is S, numerator is 4*a^2*2^(2F)
   always_comb begin
      rem_c[0]  = ROOT_W'(s_c[0]);
      root_c[0] = '0;
      for (int i = 0; i < 3; i++) begin
         rr_c[0][i] = W'(sq[i]) << (2*FRAC_BITS + 2);
         dd_c[0][i] = '0;
         uu_c[0][i] = '0;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      vn_step #(.FRAC_BITS(FRAC_BITS), .STAGE(k)) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .meta_in  (meta_c[k]),
         .s_in     (s_c[k]),
         .rem_in   (rem_c[k]),
         .root_in  (root_c[k]),
         .rr_in    (rr_c[k]),
         .dd_in    (dd_c[k]),
         .uu_in    (uu_c[k]),
         .meta_out (meta_c[k+1]),
         .s_out    (s_c[k+1]),
         .rem_out  (rem_c[k+1]),
         .root_out (root_c[k+1]),
         .rr_out   (rr_c[k+1]),
         .dd_out   (dd_c[k+1]),
         .uu_out   (uu_c[k+1])
      );
   end

   // u = floor(sqrt(N/S)); rounded magnitude q = floor((u+1)/2), then sign
   always_comb begin
      last = meta_c[SQRT_STEPS];
      for (int i = 0; i < 3; i++) begin
         q[i] = ((UW+1)'(uu_c[SQRT_STEPS][i]) + (UW+1)'(1)) >> 1;
      end
      comp[0] = last.x[DATA_W-1] ? -DATA_W'(q[0]) : DATA_W'(q[0]);
      comp[1] = last.y[DATA_W-1] ? -DATA_W'(q[1]) : DATA_W'(q[1]);
      comp[2] = last.z[DATA_W-1] ? -DATA_W'(q[2]) : DATA_W'(q[2]);
      res.is_tiny = last.tiny;
      if (last.tiny) begin
         res.x      = last.x;
         res.y      = last.y;
         res.z      = last.z;
         res.length = '0;
      end else if (last.zero) begin
         res.x      = '0;
         res.y      = '0;
         res.z      = '0;
         res.length = '0;
      end else begin
         res.x      = comp[0];
         res.y      = comp[1];
         res.z      = comp[2];
         res.length = root_c[SQRT_STEPS][DATA_W-1:0];
      end
   end

   vn_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (last.valid && en),
      .in_data    (res),
      .rsp_tready (rsp_tready),
      .out_valid  (out_valid),
      .out_data   (out),
      .full       (full)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {out.length, out.z, out.y, out.x};
   assign rsp_tuser  = out.is_tiny;
endmodule
`default_nettype wire
